// ===== rtl/square_frame_rotator_unit_assert.svh =====
// Assertion helpers used by the rotator control module.
`ifndef SQUARE_FRAME_ROTATOR_UNIT_ASSERT_SVH
`define SQUARE_FRAME_ROTATOR_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SFR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int MAX_SIDE     = 64;
   localparam int PIXEL_BITS   = 16;

   localparam int COORD_W      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SIDE_W       = COORD_W + 1;
   localparam int ADDR_W       = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int STORE_DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int TOT_W        = 2 * SIDE_W;
   localparam int PROD_W       = COORD_W + SIDE_W;
   localparam int DATA_W       = ((PIXEL_BITS + 7) / 8) * 8;

   localparam int SIDE_FIELD_W = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [SIDE_FIELD_W-1:0] SIDE_RESET = SIDE_FIELD_W'(MAX_SIDE);

   // Word kinds carried on the request tuser bit.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // Rotation modes.
   localparam logic ROT_90  = 1'b0;
   localparam logic ROT_270 = 1'b1;

   // Register indexes (byte address bit 2).
   localparam logic REG_ROTATE_MODE = 1'b0;
   localparam logic REG_FRAME_SIDE  = 1'b1;

   typedef enum logic {
      ST_LOAD,
      ST_READOUT
   } state_type;

   typedef struct packed {
      logic                    rotate_mode;
      logic [SIDE_FIELD_W-1:0] frame_side;
   } cfg_type;

   typedef struct packed {
      logic load;   // write pixel, advance load position
      logic read;   // read rotated pixel, advance readout position
      logic empty;  // answer a pull with the empty flag
   } cmd_type;

   typedef struct packed {
      logic load_done;  // this load completes the frame
      logic read_last;  // this read is the final pixel of the frame
   } status_type;

endpackage

// ===== rtl/sfr_ram.sv =====
`timescale 1ns / 1ps

module sfr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sfr_csr.sv =====
`timescale 1ns / 1ps

module sfr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output sfr_pkg::cfg_type               cfg
);
   import sfr_pkg::*;

   logic                    rotate_mode_ff, rotate_mode_in;
   logic [SIDE_FIELD_W-1:0] frame_side_ff, frame_side_in;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      rotate_mode_in = rotate_mode_ff;
      frame_side_in  = frame_side_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_ROTATE_MODE: rotate_mode_in = csr_pwdata[0];
            REG_FRAME_SIDE:  frame_side_in  = csr_pwdata[SIDE_FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_mode_ff <= ROT_90;
         frame_side_ff  <= SIDE_RESET;
      end else begin
         rotate_mode_ff <= rotate_mode_in;
         frame_side_ff  <= frame_side_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ROTATE_MODE: csr_prdata = CSR_DATA_W'(rotate_mode_ff);
         REG_FRAME_SIDE:  csr_prdata = CSR_DATA_W'(frame_side_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.rotate_mode = rotate_mode_ff;
   assign cfg.frame_side  = frame_side_ff;

endmodule

// ===== rtl/sfr_datapath.sv =====
`timescale 1ns / 1ps

module sfr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  sfr_pkg::cfg_type               cfg,
   input  sfr_pkg::cmd_type               cmd,
   input  logic [sfr_pkg::PIXEL_BITS-1:0] pixel_in,
   output sfr_pkg::status_type            sts,
   output logic [sfr_pkg::PIXEL_BITS-1:0] pixel_out,
   output logic                           frame_last,
   output logic                           empty_res
);
   import sfr_pkg::*;

   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic               last_ff, last_in, empty_ff, empty_in;

   logic [SIDE_W-1:0]  n, col_next;
   logic [COORD_W-1:0] nm1, x, y, mul_a, add_b;
   logic [TOT_W-1:0]   total, pos_next;
   logic [PROD_W-1:0]  prod;
   logic [ADDR_W-1:0]  raddr;
   logic [PIXEL_BITS-1:0] rdata;

   // Side in use: zero counts as one, oversize clamps to the store side.
   always_comb begin
      if (cfg.frame_side == '0) begin
         n = SIDE_W'(1);
      end else if (int'(cfg.frame_side) > MAX_SIDE) begin
         n = SIDE_W'(MAX_SIDE);
      end else begin
         n = SIDE_W'(cfg.frame_side);
      end
   end

   assign nm1      = COORD_W'(n - SIDE_W'(1));
   assign total    = TOT_W'(n) * TOT_W'(n);
   assign pos_next = TOT_W'(pos_ff) + TOT_W'(1);

   // Clamp readout coordinates that a shrunken side has left behind.
   assign y = ({1'b0, row_ff} < n) ? row_ff : nm1;
   assign x = ({1'b0, col_ff} < n) ? col_ff : nm1;

   always_comb begin
      if (cfg.rotate_mode == ROT_270) begin
         mul_a = x;
         add_b = nm1 - y;
      end else begin
         mul_a = nm1 - x;
         add_b = y;
      end
   end

   assign prod  = PROD_W'(mul_a) * PROD_W'(n);
   assign raddr = ADDR_W'(prod + PROD_W'(add_b));

   assign col_next      = SIDE_W'(col_ff) + SIDE_W'(1);
   assign sts.load_done = (pos_next >= total);
   assign sts.read_last = ({1'b0, row_ff} >= SIDE_W'(nm1)) && ({1'b0, col_ff} >= SIDE_W'(nm1));

   always_comb begin
      pos_in   = pos_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      last_in  = last_ff;
      empty_in = empty_ff;
      if (cmd.load) begin
         pos_in = sts.load_done ? '0 : ADDR_W'(pos_next);
      end
      if (cmd.read) begin
         last_in  = sts.read_last;
         empty_in = 1'b0;
         if (sts.read_last) begin
            row_in = '0;
            col_in = '0;
         end else if (col_next >= n) begin
            col_in = '0;
            row_in = row_ff + COORD_W'(1);
         end else begin
            col_in = COORD_W'(col_next);
         end
      end
      if (cmd.empty) begin
         last_in  = 1'b0;
         empty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      empty_ff <= empty_in;
   end

   sfr_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.load),
      .waddr (pos_ff),
      .wdata (pixel_in),
      .re    (cmd.read),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign pixel_out  = empty_ff ? '0 : rdata;
   assign frame_last = last_ff;
   assign empty_res  = empty_ff;

endmodule

// ===== rtl/sfr_ctrl.sv =====
`timescale 1ns / 1ps

`include "square_frame_rotator_unit_assert.svh"

module sfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_op,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  sfr_pkg::status_type sts,
   output sfr_pkg::cmd_type    cmd
);
   import sfr_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      req_tready = !rsp_valid_ff || rsp_tready;
      accept     = req_tvalid && req_tready;
      cmd        = '0;
      state_in   = state_ff;

      case (state_ff)
         ST_LOAD: begin
            cmd.load  = accept && (req_op == OP_LOAD);
            cmd.empty = accept && (req_op == OP_PULL);
            if (cmd.load && sts.load_done) begin
               state_in = ST_READOUT;
            end
         end
         ST_READOUT: begin
            // Drop loads while a frame awaits readout.
            cmd.read = accept && (req_op == OP_PULL);
            if (cmd.read && sts.read_last) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (accept && (req_op == OP_PULL)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `SFR_ASSERT(a_write_only_loading, cmd.load |-> (state_ff == ST_LOAD), "store written while full")
   `SFR_ASSERT(a_last_frees_store, (cmd.read && sts.read_last) |=> (state_ff == ST_LOAD), "store not freed after last")
   `SFR_ASSERT(a_pull_gives_word, (accept && (req_op == OP_PULL)) |=> rsp_valid_ff, "pull lost its result")
   `SFR_ASSERT_ALWAYS(a_stall_only_on_result, !req_tready |-> rsp_valid_ff, "request stalled without a pending result")

endmodule

// ===== rtl/square_frame_rotator_unit.sv =====
`timescale 1ns / 1ps

// Square frame rotator: turns a square frame of up to 64 x 64 16-bit pixels by
// 90 (rotate_mode 0) or 270 (rotate_mode 1) degrees clockwise. Send words on the
// req channel with tuser 0 to load pixels in source raster order; once
// frame_side * frame_side pixels are in, the frame store is full and further loads
// are dropped. Send words with tuser 1 to pull the rotated frame in output raster
// order; every pull returns exactly one rsp word, with tlast on the final pixel of
// the frame, after which the store is free for the next load. A pull while the
// frame is incomplete returns a zero pixel with tuser (empty) set. Loads return no word.
// Both phases run at one word per clock: a pulled pixel appears on rsp the cycle
// after it is accepted, from the registered read port of the single-port-write
// frame store, and req_tready drops only while a result is held and rsp_tready is
// low. Write rotate_mode and frame_side (0 counts as 1, above 64 as 64) while idle.
module square_frame_rotator_unit (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sfr_pkg::DATA_W-1:0]     req_tdata,   // [15:0] pixel_in
   input  logic                           req_tuser,   // [0] op
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sfr_pkg::DATA_W-1:0]     rsp_tdata,   // [15:0] pixel_out
   output logic                           rsp_tlast,   // frame_last
   output logic                           rsp_tuser,   // [0] empty_res
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sfr_pkg::*;

   cfg_type               cfg;
   cmd_type               cmd;
   status_type            sts;
   logic [PIXEL_BITS-1:0] pixel_out;

   sfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequence loads and pulls, own the result valid.
   sfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold counters, rotated address, frame store and result flags.
   sfr_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .pixel_in   (req_tdata[PIXEL_BITS-1:0]),
      .sts        (sts),
      .pixel_out  (pixel_out),
      .frame_last (rsp_tlast),
      .empty_res  (rsp_tuser)
   );

   assign rsp_tdata = DATA_W'(pixel_out);

endmodule
